@@ rtl/pdxc_pkg.sv @@
// ----------------------------------------------------------------------------
// Packet deframer package
// Shared status codes, register indexes and widths for the deframer.
// ----------------------------------------------------------------------------
package pdxc_pkg;

   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned LEN_WIDTH    = 16;
   localparam int unsigned STATUS_WIDTH = 2;
   localparam int unsigned CSR_IDX_WIDTH  = 1;
   localparam int unsigned CSR_DATA_WIDTH = 16;

   // Status reported with each result item.
   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK           = 2'd0,
      ST_BAD_VERSION  = 2'd1,
      ST_TOO_LONG     = 2'd2,
      ST_BAD_CHECKSUM = 2'd3
   } status_type;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_EXPECTED_VERSION   = 1'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_PAYLOAD_LENGTH = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [BYTE_WIDTH-1:0] EXPECTED_VERSION_RESET   = 8'd1;
   localparam logic [LEN_WIDTH-1:0]  MAX_PAYLOAD_LENGTH_RESET = 16'd256;

endpackage

@@ rtl/packet_deframer_xor_check_unit.sv @@
// ----------------------------------------------------------------------------
// Packet deframer with XOR checksum
// Parses version / id / length / payload / checksum frames from a byte stream.
// ----------------------------------------------------------------------------
// The unit takes one received byte per input item and parses frames made of a
// version byte, an id byte, a big-endian 16-bit payload length, the payload
// bytes and a checksum byte that is the XOR of every earlier byte of the frame.
// Header bytes produce no result unless the header fails. After the fourth
// header byte the version is checked against expected_version and then the
// length against max_payload_length; a failure produces an end item with
// status 1 or 2 and the unit hunts for a new header. Each payload byte is
// passed out as a data item, and the checksum byte closes the frame with an
// end item carrying status 0 (match) or 3 (mismatch). Every result item also
// carries the id and declared length of the current frame. An accepted byte
// lands in an input register, a single pass of byte-wide logic updates the
// parser state and fills the result register, so with rsp_ready held high the
// unit sustains one item per cycle, and rsp_valid rises once the result of a
// byte has passed from the input register into the result register. The
// result register is only refilled when it is empty or being drained, so a
// stalled consumer holds the pipeline without losing items. Configuration
// writes are taken at any time (csr_ready is always high) and should only be
// issued while the unit is idle.
module packet_deframer_xor_check_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input byte channel.
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [pdxc_pkg::BYTE_WIDTH-1:0]       req_rx_byte,
   // Result channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_is_end,
   output logic [pdxc_pkg::BYTE_WIDTH-1:0]       rsp_data_byte,
   output logic [pdxc_pkg::BYTE_WIDTH-1:0]       rsp_packet_id,
   output logic [pdxc_pkg::LEN_WIDTH-1:0]        rsp_payload_length,
   output logic [pdxc_pkg::STATUS_WIDTH-1:0]     rsp_status,
   // Configuration write channel.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pdxc_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [pdxc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   import pdxc_pkg::*;

   // Parser phase.
   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_CHECK   = 2'd2
   } phase_type;

   // Configuration registers.
   logic [BYTE_WIDTH-1:0] expected_version_ff;
   logic [LEN_WIDTH-1:0]  max_payload_length_ff;

   // Input register.
   logic                  in_valid_ff;
   logic [BYTE_WIDTH-1:0] in_byte_ff;

   // Parser state.
   phase_type             phase_ff,        phase_in;
   logic [1:0]            header_count_ff, header_count_in;
   logic [BYTE_WIDTH-1:0] version_seen_ff, version_seen_in;
   logic [BYTE_WIDTH-1:0] frame_id_ff,     frame_id_in;
   logic [LEN_WIDTH-1:0]  frame_length_ff, frame_length_in;
   logic [LEN_WIDTH-1:0]  bytes_left_ff,   bytes_left_in;
   logic [BYTE_WIDTH-1:0] running_xor_ff,  running_xor_in;

   // Result register.
   logic                  out_valid_ff;
   logic                  out_is_end_ff;
   logic [BYTE_WIDTH-1:0] out_data_ff;
   logic [BYTE_WIDTH-1:0] out_id_ff;
   logic [LEN_WIDTH-1:0]  out_length_ff;
   status_type            out_status_ff;

   // Single-pass result of the byte held in the input register.
   logic                  advance;
   logic                  emit;
   logic                  emit_is_end;
   logic [BYTE_WIDTH-1:0] emit_data;
   status_type            emit_status;

   // The held byte is processed once the result register can take its result.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      version_seen_in = version_seen_ff;
      frame_id_in     = frame_id_ff;
      frame_length_in = frame_length_ff;
      bytes_left_in   = bytes_left_ff;
      running_xor_in  = running_xor_ff;
      emit            = 1'b0;
      emit_is_end     = 1'b0;
      emit_data       = '0;
      emit_status     = ST_OK;

      if (advance) begin
         unique case (phase_ff)
            PH_PAYLOAD: begin
               running_xor_in = running_xor_ff ^ in_byte_ff;
               bytes_left_in  = bytes_left_ff - LEN_WIDTH'(1);
               if (bytes_left_in == '0) begin
                  phase_in = PH_CHECK;
               end
               emit      = 1'b1;
               emit_data = in_byte_ff;
            end
            PH_CHECK: begin
               phase_in        = PH_HUNT;
               header_count_in = 2'd0;
               emit            = 1'b1;
               emit_is_end     = 1'b1;
               emit_status     = (in_byte_ff == running_xor_ff) ? ST_OK : ST_BAD_CHECKSUM;
            end
            default: begin
               // Hunting for a header; the unused phase code lands here too.
               phase_in = PH_HUNT;
               case (header_count_ff)
                  2'd0: begin
                     version_seen_in = in_byte_ff;
                     running_xor_in  = in_byte_ff;
                     header_count_in = 2'd1;
                  end
                  2'd1: begin
                     frame_id_in     = in_byte_ff;
                     running_xor_in  = running_xor_ff ^ in_byte_ff;
                     header_count_in = 2'd2;
                  end
                  2'd2: begin
                     frame_length_in = {in_byte_ff, BYTE_WIDTH'(0)};
                     running_xor_in  = running_xor_ff ^ in_byte_ff;
                     header_count_in = 2'd3;
                  end
                  default: begin
                     frame_length_in = {frame_length_ff[LEN_WIDTH-1:BYTE_WIDTH], in_byte_ff};
                     running_xor_in  = running_xor_ff ^ in_byte_ff;
                     header_count_in = 2'd0;
                     if (version_seen_ff != expected_version_ff) begin
                        emit        = 1'b1;
                        emit_is_end = 1'b1;
                        emit_status = ST_BAD_VERSION;
                     end else if (frame_length_in > max_payload_length_ff) begin
                        emit        = 1'b1;
                        emit_is_end = 1'b1;
                        emit_status = ST_TOO_LONG;
                     end else if (frame_length_in == '0) begin
                        phase_in = PH_CHECK;
                     end else begin
                        bytes_left_in = frame_length_in;
                        phase_in      = PH_PAYLOAD;
                     end
                  end
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_version_ff   <= EXPECTED_VERSION_RESET;
         max_payload_length_ff <= MAX_PAYLOAD_LENGTH_RESET;
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         phase_ff              <= PH_HUNT;
         header_count_ff       <= 2'd0;
         version_seen_ff       <= '0;
         frame_id_ff           <= '0;
         frame_length_ff       <= '0;
         bytes_left_ff         <= '0;
         running_xor_ff        <= '0;
      end else begin
         // Configuration writes; an index outside the list is ignored.
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_EXPECTED_VERSION:   expected_version_ff   <= csr_wdata[BYTE_WIDTH-1:0];
               CSR_MAX_PAYLOAD_LENGTH: max_payload_length_ff <= csr_wdata[LEN_WIDTH-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            out_valid_ff <= emit;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end

         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         version_seen_ff <= version_seen_in;
         frame_id_ff     <= frame_id_in;
         frame_length_ff <= frame_length_in;
         bytes_left_ff   <= bytes_left_in;
         running_xor_ff  <= running_xor_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && emit) begin
         out_is_end_ff <= emit_is_end;
         out_data_ff   <= emit_data;
         out_id_ff     <= frame_id_in;
         out_length_ff <= frame_length_in;
         out_status_ff <= emit_status;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_is_end         = out_is_end_ff;
   assign rsp_data_byte      = out_data_ff;
   assign rsp_packet_id      = out_id_ff;
   assign rsp_payload_length = out_length_ff;
   assign rsp_status         = out_status_ff;

endmodule

@@ tb/packet_deframer_xor_check_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packet deframer testbench
// Feeds byte streams through the deframer and checks every result item
// against a cycle-free parser model or the expected items of a table.
// ----------------------------------------------------------------------------
// A short table of hand-written bytes comes first: header errors, a good
// frame, an empty payload with a bad checksum and register writes that land
// in the middle of a header. Then four random phases run, each under its own
// register setting, including the extremes. Both the byte source and the
// result sink idle at random, one phase runs with no idling at all, and in
// one phase the sink holds off long enough for the unit to stall its input.
module tb;
   import pdxc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned PHASE_BYTES  = 480;
   localparam int unsigned HOLD_CYCLES  = 400;

   // One result item as the unit presents it.
   typedef struct packed {
      logic                   is_end;
      logic [BYTE_WIDTH-1:0]  data_byte;
      logic [BYTE_WIDTH-1:0]  packet_id;
      logic [LEN_WIDTH-1:0]   payload_length;
      status_type             status;
   } frame_result_type;

   // How the result of an offered item is worked out.
   typedef enum logic [1:0] {
      BY_PREDICTOR,
      NO_RESULT,
      TYPED_RESULT,
      REG_WRITE
   } item_check_type;

   typedef struct packed {
      item_check_type    how;
      frame_result_type  want;
   } item_offer_type;

   typedef struct packed {
      item_check_type             how;
      logic [CSR_IDX_WIDTH-1:0]   reg_idx;
      logic [CSR_DATA_WIDTH-1:0]  value;
      frame_result_type           want;
   } plan_row_type;

   typedef enum logic [1:0] {
      SEEK_HEADER,
      IN_PAYLOAD,
      AT_CHECKSUM
   } parse_state_type;

   // Directed bytes. Register values are at their reset settings when this
   // starts: version 1, longest payload 256.
   localparam plan_row_type PLAN [28] = '{
      // Empty payload, so the fifth byte is the checksum; 8'h00 is wrong.
      '{NO_RESULT,    1'b0, 16'h0001, '0},
      '{NO_RESULT,    1'b0, 16'h007E, '0},
      '{NO_RESULT,    1'b0, 16'h0000, '0},
      '{NO_RESULT,    1'b0, 16'h0000, '0},
      '{TYPED_RESULT, 1'b0, 16'h0000, '{1'b1, 8'h00, 8'h7E, 16'h0000, ST_BAD_CHECKSUM}},
      // All-ones header: the version is wrong, id and length at their top.
      '{NO_RESULT,    1'b0, 16'h00FF, '0},
      '{NO_RESULT,    1'b0, 16'h00FF, '0},
      '{NO_RESULT,    1'b0, 16'h00FF, '0},
      '{TYPED_RESULT, 1'b0, 16'h00FF, '{1'b1, 8'h00, 8'hFF, 16'hFFFF, ST_BAD_VERSION}},
      // Good frame with two payload bytes and a matching checksum.
      '{NO_RESULT,    1'b0, 16'h0001, '0},
      '{NO_RESULT,    1'b0, 16'h00C3, '0},
      '{NO_RESULT,    1'b0, 16'h0000, '0},
      '{NO_RESULT,    1'b0, 16'h0002, '0},
      '{TYPED_RESULT, 1'b0, 16'h00FF, '{1'b0, 8'hFF, 8'hC3, 16'h0002, ST_OK}},
      '{TYPED_RESULT, 1'b0, 16'h0000, '{1'b0, 8'h00, 8'hC3, 16'h0002, ST_OK}},
      '{TYPED_RESULT, 1'b0, 16'h003F, '{1'b1, 8'h00, 8'hC3, 16'h0002, ST_OK}},
      // The version register changes after two header bytes; the check that
      // follows must use the new value.
      '{NO_RESULT,    1'b0, 16'h0001, '0},
      '{NO_RESULT,    1'b0, 16'h0022, '0},
      '{REG_WRITE,    CSR_EXPECTED_VERSION, 16'h0022, '0},
      '{NO_RESULT,    1'b0, 16'h0000, '0},
      '{TYPED_RESULT, 1'b0, 16'h0000, '{1'b1, 8'h00, 8'h22, 16'h0000, ST_BAD_VERSION}},
      '{REG_WRITE,    CSR_EXPECTED_VERSION, 16'h0001, '0},
      // Same for the length limit, written between the third and fourth byte.
      '{NO_RESULT,    1'b0, 16'h0001, '0},
      '{NO_RESULT,    1'b0, 16'h0044, '0},
      '{NO_RESULT,    1'b0, 16'h0000, '0},
      '{REG_WRITE,    CSR_MAX_PAYLOAD_LENGTH, 16'h0004, '0},
      '{TYPED_RESULT, 1'b0, 16'h0005, '{1'b1, 8'h00, 8'h44, 16'h0005, ST_TOO_LONG}},
      '{REG_WRITE,    CSR_MAX_PAYLOAD_LENGTH, 16'h0100, '0}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [BYTE_WIDTH-1:0]      req_rx_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_is_end;
   logic [BYTE_WIDTH-1:0]      rsp_data_byte;
   logic [BYTE_WIDTH-1:0]      rsp_packet_id;
   logic [LEN_WIDTH-1:0]       rsp_payload_length;
   logic [STATUS_WIDTH-1:0]    rsp_status;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_WIDTH-1:0]   csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Items offered but not yet accepted, results still owed by the unit and
   // the bytes of the random phase being built.
   item_offer_type     offer_q[$];
   frame_result_type   result_q[$];
   logic [7:0]         stream_q[$];

   int unsigned        mismatches = 0;
   int unsigned        cycles = 0;
   int unsigned        idle_pct = 36;
   int unsigned        hold_left = 0;
   bit                 hold_off_req = 1'b0;

   // Parser state and register copies of the testbench model.
   logic [7:0]         want_version = EXPECTED_VERSION_RESET;
   logic [15:0]        len_limit = MAX_PAYLOAD_LENGTH_RESET;
   parse_state_type    parse_at = SEEK_HEADER;
   logic [1:0]         hdr_taken = 2'd0;
   logic [7:0]         ver_got = 8'h00;
   logic [7:0]         cur_id = 8'h00;
   logic [15:0]        cur_len = 16'h0000;
   logic [15:0]        remaining = 16'h0000;
   logic [7:0]         xor_acc = 8'h00;

   packet_deframer_xor_check_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_end         (rsp_is_end),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_packet_id      (rsp_packet_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // Advances the parser by one received byte. A result is made for every
   // payload byte, for the checksum byte, and for a header that fails.
   task automatic deframe_byte(input logic [7:0] b, output logic made,
                               output frame_result_type r);
      made = 1'b0;
      r = '{1'b0, 8'h00, cur_id, cur_len, ST_OK};
      case (parse_at)
         IN_PAYLOAD: begin
            xor_acc = xor_acc ^ b;
            remaining = remaining - 16'd1;
            if (remaining == 16'd0) parse_at = AT_CHECKSUM;
            made = 1'b1;
            r.data_byte = b;
         end
         AT_CHECKSUM: begin
            made = 1'b1;
            r.is_end = 1'b1;
            r.status = (b == xor_acc) ? ST_OK : ST_BAD_CHECKSUM;
            parse_at = SEEK_HEADER;
            hdr_taken = 2'd0;
         end
         default: begin
            parse_at = SEEK_HEADER;
            case (hdr_taken)
               2'd0: begin
                  ver_got = b;
                  xor_acc = b;
                  hdr_taken = 2'd1;
               end
               2'd1: begin
                  cur_id = b;
                  xor_acc = xor_acc ^ b;
                  hdr_taken = 2'd2;
               end
               2'd2: begin
                  cur_len = {b, 8'h00};
                  xor_acc = xor_acc ^ b;
                  hdr_taken = 2'd3;
               end
               default: begin
                  // Last header byte: version first, then the length limit.
                  cur_len[7:0] = b;
                  xor_acc = xor_acc ^ b;
                  hdr_taken = 2'd0;
                  r.is_end = 1'b1;
                  r.packet_id = cur_id;
                  r.payload_length = cur_len;
                  if (ver_got != want_version) begin
                     made = 1'b1;
                     r.status = ST_BAD_VERSION;
                  end else if (cur_len > len_limit) begin
                     made = 1'b1;
                     r.status = ST_TOO_LONG;
                  end else if (cur_len == 16'd0) begin
                     parse_at = AT_CHECKSUM;
                  end else begin
                     remaining = cur_len;
                     parse_at = IN_PAYLOAD;
                  end
               end
            endcase
         end
      endcase
   endtask

   task automatic flag_result(input string why, input frame_result_type want,
                              input frame_result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch, %s: expected end=%0d data=%02h id=%02h len=%04h st=%0d",
                  why, want.is_end, want.data_byte, want.packet_id,
                  want.payload_length, want.status);
         $display("             got end=%0d data=%02h id=%02h len=%04h st=%0d",
                  got.is_end, got.data_byte, got.packet_id, got.payload_length,
                  got.status);
      end
   endtask

   // Watches all three channels at the clock edge. Accepted bytes run through
   // the model, accepted register writes update its copies, and each accepted
   // result is held against the oldest outstanding expectation.
   always @(posedge clock) begin : watch
      item_offer_type    rec;
      logic              made;
      frame_result_type  res;
      frame_result_type  got;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EXPECTED_VERSION:   want_version = csr_wdata[7:0];
               CSR_MAX_PAYLOAD_LENGTH: len_limit = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            rec = offer_q.pop_front();
            deframe_byte(req_rx_byte, made, res);
            case (rec.how)
               BY_PREDICTOR: if (made) result_q.push_back(res);
               TYPED_RESULT: result_q.push_back(rec.want);
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_is_end, rsp_data_byte, rsp_packet_id, rsp_payload_length,
                    status_type'(rsp_status)};
            if (result_q.size() == 0) begin
               flag_result("result with nothing outstanding", '0, got);
            end else begin
               res = result_q.pop_front();
               if (got.is_end !== res.is_end || got.data_byte !== res.data_byte ||
                   got.packet_id !== res.packet_id ||
                   got.payload_length !== res.payload_length ||
                   got.status !== res.status) begin
                  flag_result("wrong field", res, got);
               end
            end
         end
      end
   end

   // Result sink. A requested hold-off keeps rsp_ready low for a long count
   // of cycles so the unit fills up and has to push back on its input.
   always @(posedge clock) begin
      if (hold_off_req) begin
         hold_left = HOLD_CYCLES;
         hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb NOT OK");
         $finish;
      end
   end

   // Offers one byte and returns at the edge where it is accepted. The next
   // call either keeps valid high with a new byte or drops it for a gap.
   task automatic offer_byte(input logic [7:0] b, input item_check_type how,
                             input frame_result_type want);
      offer_q.push_back('{how, want});
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every byte is taken and every result has come out, then
   // lets the pipeline settle, since header bytes leave no trace to wait on.
   task automatic wait_idle(input int unsigned settle);
      req_valid <= 1'b0;
      while (offer_q.size() != 0 || result_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Appends one frame to the stream. Most frames are well formed with
   // random content; the rest carry a wrong version, a length over the limit,
   // a bad checksum, or are a few stray bytes that knock the parser out of
   // step. A non-negative forced_len gives a frame of that length, good within the limit.
   task automatic append_frame(input logic [7:0] ver, input logic [15:0] lim,
                               input int forced_len);
      int unsigned  pick;
      int unsigned  cap;
      logic [7:0]   v;
      logic [7:0]   fid;
      logic [7:0]   sum;
      logic [7:0]   b;
      logic [15:0]  flen;
      pick = $urandom_range(0, 99);
      v = ver;
      fid = 8'($urandom_range(0, 255));
      if (forced_len >= 0) begin
         flen = 16'(forced_len);
      end else if (pick < 4 && lim < 16'd1024) begin
         // Stray bytes; kept out of the widest setting, where a misread
         // header could swallow the rest of the phase as payload.
         repeat ($urandom_range(1, 3)) stream_q.push_back(8'($urandom_range(0, 255)));
         return;
      end else if (pick < 14) begin
         v = ver ^ 8'($urandom_range(1, 255));
         flen = 16'($urandom_range(0, 65535));
      end else if (pick < 24 && lim != 16'hFFFF) begin
         flen = 16'($urandom_range(int'(lim) + 1, 65535));
      end else begin
         cap = ($urandom_range(0, 19) == 0) ? 300 : 24;
         if (cap > lim) cap = 32'(lim);
         flen = 16'($urandom_range(0, cap));
      end
      stream_q.push_back(v);
      stream_q.push_back(fid);
      stream_q.push_back(flen[15:8]);
      stream_q.push_back(flen[7:0]);
      sum = v ^ fid ^ flen[15:8] ^ flen[7:0];
      if (v != ver || flen > lim) return;
      repeat (flen) begin
         b = 8'($urandom_range(0, 255));
         stream_q.push_back(b);
         sum = sum ^ b;
      end
      if (forced_len < 0 && $urandom_range(0, 6) == 0) sum = sum ^ 8'($urandom_range(1, 255));
      stream_q.push_back(sum);
   endtask

   // One random phase under a fresh register setting. With squeeze set, the
   // sink holds off while the phase's bytes are being offered. With at_limit
   // set, it opens with a frame of exactly the limit and one just over it.
   task automatic run_phase(input logic [7:0] ver, input logic [15:0] lim,
                            input bit squeeze, input bit at_limit);
      wait_idle(4);
      write_reg(CSR_EXPECTED_VERSION, {8'h00, ver});
      write_reg(CSR_MAX_PAYLOAD_LENGTH, lim);
      if (squeeze) hold_off_req = 1'b1;
      if (at_limit) begin
         append_frame(ver, lim, int'(lim));
         append_frame(ver, lim, int'(lim) + 1);
      end
      while (stream_q.size() < PHASE_BYTES) append_frame(ver, lim, -1);
      while (stream_q.size() != 0) offer_byte(stream_q.pop_front(), BY_PREDICTOR, '0);
   endtask

   initial begin : stimulus
      logic [7:0]   rand_ver;
      logic [15:0]  rand_lim;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(PLAN); i++) begin
         if (PLAN[i].how == REG_WRITE) begin
            wait_idle(4);
            write_reg(PLAN[i].reg_idx, PLAN[i].value);
         end else begin
            offer_byte(PLAN[i].value[7:0], PLAN[i].how, PLAN[i].want);
         end
      end

      // Lowest setting: only empty payloads pass the length check.
      run_phase(8'h00, 16'h0000, 1'b0, 1'b0);

      // Highest setting, with neither side idling.
      idle_pct = 0;
      run_phase(8'hFF, 16'hFFFF, 1'b0, 1'b0);
      idle_pct = 36;

      // Random setting with a tight limit, and a long stall on the sink.
      rand_ver = 8'($urandom_range(0, 255));
      rand_lim = 16'($urandom_range(1, 40));
      run_phase(rand_ver, rand_lim, 1'b1, 1'b0);

      // Back to the reset values, written explicitly this time.
      run_phase(EXPECTED_VERSION_RESET, MAX_PAYLOAD_LENGTH_RESET, 1'b0, 1'b1);

      wait_idle(20);
      if (mismatches == 0 && result_q.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
